>>> src/lsf_pkg.sv
// Shared constants, types and codes for the learning switch forwarding block.
package lsf_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int NUM_PORTS     = 8;

    localparam int ADDR_W  = 48;
    localparam int PORT_W  = 3;
    localparam int MASK_W  = 8;
    localparam int ACT_W   = 2;
    localparam int CNT_W   = 4;
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [ADDR_W-1:0] BROADCAST_ADDR = {ADDR_W{1'b1}};

    localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FLOOD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FILTER  = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_PORTS_IN_USE = 1'b0;

    localparam logic [CNT_W-1:0] PORTS_IN_USE_RESET = 4'd8;
    localparam logic [CNT_W-1:0] NUM_PORTS_CNT      = CNT_W'(NUM_PORTS);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [PORT_W-1:0] t_port;

    // table answer for the frame held in the input register
    typedef struct packed {
        logic  dst_hit;
        t_port dst_port;
        logic  src_learned;
    } t_lookup;

endpackage

>>> src/lsf_hdr_if.sv
// Frame header channel: source and destination addresses plus ingress port.
interface lsf_hdr_if;
    logic                       valid;
    logic                       ready;
    logic [lsf_pkg::ADDR_W-1:0] source_address;
    logic [lsf_pkg::ADDR_W-1:0] destination_address;
    logic [lsf_pkg::PORT_W-1:0] ingress_port;

    modport source (output valid, source_address, destination_address, ingress_port,
                    input ready);
    modport sink   (input valid, source_address, destination_address, ingress_port,
                    output ready);
endinterface

>>> src/lsf_res_if.sv
// Forwarding decision channel: action, egress port and egress mask.
interface lsf_res_if;
    logic                       valid;
    logic                       ready;
    logic [lsf_pkg::ACT_W-1:0]  action;
    logic [lsf_pkg::PORT_W-1:0] egress_port;
    logic [lsf_pkg::MASK_W-1:0] egress_mask;

    modport source (output valid, action, egress_port, egress_mask, input ready);
    modport sink   (input valid, action, egress_port, egress_mask, output ready);
endinterface

>>> src/lsf_cfg_regs.sv
// APB register block holding the active port count.
module lsf_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsf_pkg::PADDR_W-1:0] paddr,
    input  logic [lsf_pkg::PDATA_W-1:0] pwdata,
    output logic [lsf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [lsf_pkg::CNT_W-1:0]   o_ports_in_use
);
    logic [lsf_pkg::CNT_W-1:0] r_ports_in_use;
    logic                      reg_idx;

    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ports_in_use <= lsf_pkg::PORTS_IN_USE_RESET;
        end else if (psel && penable && pwrite && (reg_idx == lsf_pkg::REG_PORTS_IN_USE)) begin
            r_ports_in_use <= pwdata[lsf_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            lsf_pkg::REG_PORTS_IN_USE: begin
                prdata = {{(lsf_pkg::PDATA_W-lsf_pkg::CNT_W){1'b0}}, r_ports_in_use};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_ports_in_use = r_ports_in_use;
endmodule

>>> src/lsf_mac_table.sv
// Fully associative MAC table: parallel compare, lookup and learn write-back.
module lsf_mac_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lsf_pkg::t_addr   i_src,
    input  lsf_pkg::t_addr   i_dst,
    input  lsf_pkg::t_port   i_ingress,
    input  logic             i_learn_en,
    output lsf_pkg::t_lookup o_lookup
);
    localparam int N = lsf_pkg::TABLE_ENTRIES;

    logic [N-1:0]        r_valid;
    lsf_pkg::t_addr      r_addr [N];
    lsf_pkg::t_port      r_port [N];

    logic [N-1:0]                src_match;
    logic [N-1:0]                dst_match;
    logic                        src_hit;
    logic                        dst_hit;
    logic                        free_any;
    logic [lsf_pkg::IDX_W-1:0]   src_idx;
    logic [lsf_pkg::IDX_W-1:0]   dst_idx;
    logic [lsf_pkg::IDX_W-1:0]   free_idx;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            src_match[i] = r_valid[i] && (r_addr[i] == i_src);
            dst_match[i] = r_valid[i] && (r_addr[i] == i_dst);
        end
    end

    // lowest index wins in all three searches
    always_comb begin
        src_hit  = 1'b0;
        dst_hit  = 1'b0;
        free_any = 1'b0;
        src_idx  = '0;
        dst_idx  = '0;
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (src_match[i]) begin
                src_hit = 1'b1;
                src_idx = lsf_pkg::IDX_W'(i);
            end
            if (dst_match[i]) begin
                dst_hit = 1'b1;
                dst_idx = lsf_pkg::IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = lsf_pkg::IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_learn_en && !src_hit && free_any) begin
            r_valid[free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_learn_en) begin
            if (src_hit) begin
                r_port[src_idx] <= i_ingress;
            end else if (free_any) begin
                r_addr[free_idx] <= i_src;
                r_port[free_idx] <= i_ingress;
            end
        end
    end

    assign o_lookup.dst_hit     = dst_hit;
    assign o_lookup.dst_port    = r_port[dst_idx];
    assign o_lookup.src_learned = src_hit || free_any;
endmodule

>>> src/learning_switch_forwarding.sv
// Top level of the learning switch forwarding block.
// Takes one frame header per cycle unless the result channel stalls, and returns one forwarding
// decision per header after the input register, then the result register. The learn write-back
// and the lookup of the header held in the input register happen in the same cycle, so each
// header sees every address learned from the headers before it; the source is learned before the
// destination is looked up. The table holds TABLE_ENTRIES addresses and stops learning when
// full. Flooding covers ports below ports_in_use (register 0, capped at NUM_PORTS), minus the
// ingress port. The header channel stays ready whenever the result register is empty or its
// word is being taken.
module learning_switch_forwarding (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lsf_hdr_if.sink                     i_hdr,
    lsf_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsf_pkg::PADDR_W-1:0] paddr,
    input  logic [lsf_pkg::PDATA_W-1:0] pwdata,
    output logic [lsf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    logic [lsf_pkg::CNT_W-1:0]  ports_in_use;

    logic                       r_in_valid;
    lsf_pkg::t_addr             r_src;
    lsf_pkg::t_addr             r_dst;
    lsf_pkg::t_port             r_ing;

    logic                       r_out_valid;
    logic [lsf_pkg::ACT_W-1:0]  r_action;
    lsf_pkg::t_port             r_port;
    logic [lsf_pkg::MASK_W-1:0] r_mask;

    logic [lsf_pkg::ACT_W-1:0]  n_action;
    lsf_pkg::t_port             n_port;
    logic [lsf_pkg::MASK_W-1:0] n_mask;

    lsf_pkg::t_lookup           lookup;
    logic                       advance;
    logic                       in_take;
    logic [lsf_pkg::CNT_W-1:0]  flood_cnt;
    logic [lsf_pkg::MASK_W-1:0] flood_mask;
    logic                       self_dst;

    lsf_cfg_regs u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_ports_in_use (ports_in_use)
    );

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_hdr.ready = !r_in_valid || advance;
    assign in_take     = i_hdr.valid && i_hdr.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_src <= i_hdr.source_address;
            r_dst <= i_hdr.destination_address;
            r_ing <= i_hdr.ingress_port;
        end
    end

    lsf_mac_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_src      (r_src),
        .i_dst      (r_dst),
        .i_ingress  (r_ing),
        .i_learn_en (advance),
        .o_lookup   (lookup)
    );

    assign flood_cnt = (ports_in_use > lsf_pkg::NUM_PORTS_CNT) ? lsf_pkg::NUM_PORTS_CNT
                                                                : ports_in_use;

    always_comb begin
        for (int p = 0; p < lsf_pkg::MASK_W; p++) begin
            flood_mask[p] = (lsf_pkg::CNT_W'(p) < flood_cnt) && (lsf_pkg::PORT_W'(p) != r_ing);
        end
    end

    // destination equal to the source resolves to the entry being learned now
    assign self_dst = (r_dst == r_src) && lookup.src_learned;

    always_comb begin
        n_action = lsf_pkg::ACT_FLOOD;
        n_port   = '0;
        n_mask   = flood_mask;
        if (r_dst == lsf_pkg::BROADCAST_ADDR) begin
            n_action = lsf_pkg::ACT_FLOOD;
        end else if (self_dst) begin
            n_action = lsf_pkg::ACT_FILTER;
            n_mask   = '0;
        end else if (lookup.dst_hit) begin
            if (lookup.dst_port == r_ing) begin
                n_action = lsf_pkg::ACT_FILTER;
                n_mask   = '0;
            end else begin
                n_action = lsf_pkg::ACT_FORWARD;
                n_port   = lookup.dst_port;
                n_mask   = lsf_pkg::MASK_W'(1) << lookup.dst_port;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_action <= n_action;
            r_port   <= n_port;
            r_mask   <= n_mask;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.action      = r_action;
    assign o_res.egress_port = r_port;
    assign o_res.egress_mask = r_mask;

    a_filter_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_action == lsf_pkg::ACT_FILTER) |-> (r_mask == '0))
        else $error("filtered word carries a nonzero mask");

    a_forward_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_action == lsf_pkg::ACT_FORWARD) |-> $onehot(r_mask))
        else $error("forwarded word does not name exactly one port");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |-> !advance)
        else $error("result register overwritten while stalled");

    a_port_only_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_action != lsf_pkg::ACT_FORWARD) |-> (r_port == '0))
        else $error("egress port set on a word that is not forwarded");
endmodule

>>> verif/tb_learning_switch_forwarding.sv
// Self-checking testbench for the learning switch forwarding block: learning, lookup, flooding, stalls.
`timescale 1ns / 1ps

module tb_learning_switch_forwarding;

    typedef struct packed {
        logic [lsf_pkg::ACT_W-1:0]  action;
        lsf_pkg::t_port             egress_port;
        logic [lsf_pkg::MASK_W-1:0] egress_mask;
    } t_decision;

    typedef struct {
        lsf_pkg::t_addr src;
        lsf_pkg::t_addr dst;
        lsf_pkg::t_port ingress;
        bit             typed;
        t_decision      want;
    } t_header_row;

    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int PRESSURE_PHASE = 1;
    localparam int PRESSURE_CYCLES = 64;
    localparam int DRAIN_CYCLES   = 4;
    localparam int MAX_REPORTS    = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [lsf_pkg::PADDR_W-1:0] paddr;
    logic [lsf_pkg::PDATA_W-1:0] pwdata;
    logic [lsf_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    lsf_hdr_if hdr_bus ();
    lsf_res_if res_bus ();

    learning_switch_forwarding dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (hdr_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state: a copy of the MAC table and the active port count
    logic                      mac_valid [lsf_pkg::TABLE_ENTRIES];
    lsf_pkg::t_addr            mac_key   [lsf_pkg::TABLE_ENTRIES];
    lsf_pkg::t_port            mac_port  [lsf_pkg::TABLE_ENTRIES];
    logic [lsf_pkg::CNT_W-1:0] active_ports;

    t_decision      pending_decisions[$];
    t_header_row    header_script[$];
    lsf_pkg::t_addr addr_pool[$];

    int  fault_count;
    int  headers_sent;
    int  seen_forward;
    int  seen_flood;
    int  seen_filter;
    int  settings_run;
    bit  quiet_phase;
    int  stall_request;

    function automatic logic [lsf_pkg::MASK_W-1:0] flood_mask(lsf_pkg::t_port ingress);
        int count;
        int bits;
        count = int'(active_ports);
        if (count > lsf_pkg::NUM_PORTS) count = lsf_pkg::NUM_PORTS;
        bits = ((1 << count) - 1) & ~(1 << ingress);
        return bits[lsf_pkg::MASK_W-1:0];
    endfunction

    function automatic int find_mac(lsf_pkg::t_addr addr);
        for (int i = 0; i < lsf_pkg::TABLE_ENTRIES; i++)
            if (mac_valid[i] && mac_key[i] == addr) return i;
        return -1;
    endfunction

    // learn the source first, then decide on the destination
    task automatic predict_decision(input lsf_pkg::t_addr src, input lsf_pkg::t_addr dst,
                                    input lsf_pkg::t_port ingress, output t_decision d);
        int slot;
        slot = find_mac(src);
        if (slot >= 0) begin
            mac_port[slot] = ingress;
        end else begin
            for (int i = 0; i < lsf_pkg::TABLE_ENTRIES; i++) begin
                if (slot < 0 && !mac_valid[i]) slot = i;
            end
            if (slot >= 0) begin
                mac_valid[slot] = 1'b1;
                mac_key[slot]   = src;
                mac_port[slot]  = ingress;
            end
        end
        d = '{action: lsf_pkg::ACT_FLOOD, egress_port: '0, egress_mask: flood_mask(ingress)};
        if (dst != lsf_pkg::BROADCAST_ADDR) begin
            slot = find_mac(dst);
            if (slot >= 0) begin
                if (mac_port[slot] == ingress) begin
                    d = '{action: lsf_pkg::ACT_FILTER, egress_port: '0, egress_mask: '0};
                end else begin
                    d.action      = lsf_pkg::ACT_FORWARD;
                    d.egress_port = mac_port[slot];
                    d.egress_mask = lsf_pkg::MASK_W'(1) << mac_port[slot];
                end
            end
        end
    endtask

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 15);
        if (r < 9) return 0;
        if (r < 15) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic lsf_pkg::t_addr random_addr();
        return lsf_pkg::t_addr'({$urandom(), $urandom()});
    endfunction

    task automatic add_row(input lsf_pkg::t_addr src, input lsf_pkg::t_addr dst,
                           input lsf_pkg::t_port ingress, input bit typed,
                           input logic [lsf_pkg::ACT_W-1:0] act,
                           input lsf_pkg::t_port port,
                           input logic [lsf_pkg::MASK_W-1:0] mask);
        t_header_row row;
        row.src     = src;
        row.dst     = dst;
        row.ingress = ingress;
        row.typed   = typed;
        row.want    = '{action: act, egress_port: port, egress_mask: mask};
        header_script = {header_script, row};
    endtask

    // call at a rising edge; returns at the edge where the word is taken, or after the gap that follows it
    task automatic send_header(input lsf_pkg::t_addr src, input lsf_pkg::t_addr dst,
                               input lsf_pkg::t_port ingress, input bit typed,
                               input t_decision want, input int gap);
        t_decision calc;
        hdr_bus.valid               <= 1'b1;
        hdr_bus.source_address      <= src;
        hdr_bus.destination_address <= dst;
        hdr_bus.ingress_port        <= ingress;
        do @(posedge i_clk); while (hdr_bus.ready !== 1'b1);
        predict_decision(src, dst, ingress, calc);
        pending_decisions = {pending_decisions, (typed ? want : calc)};
        headers_sent++;
        if (gap > 0) begin
            hdr_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_ports_in_use(input logic [lsf_pkg::CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {lsf_pkg::REG_PORTS_IN_USE, 2'b00};
        pwdata  <= lsf_pkg::PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        active_ports = value;
    endtask

    task automatic drain_results();
        hdr_bus.valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    // result side: random back-pressure plus one long hold-off
    initial begin
        int  hold;
        bit  pressure_seen;
        int  r;
        hold          = 0;
        pressure_seen = 1'b0;
        res_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!pressure_seen && stall_request != 0) begin
                pressure_seen = 1'b1;
                hold          = stall_request;
            end
            if (hold > 0) begin
                hold--;
                res_bus.ready <= 1'b0;
            end else if (quiet_phase) begin
                res_bus.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 15);
                if (r < 11) begin
                    res_bus.ready <= 1'b1;
                end else begin
                    hold = (r < 15) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                    res_bus.ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_decision got;
        t_decision want;
        if (i_rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            got = '{action: res_bus.action, egress_port: res_bus.egress_port,
                    egress_mask: res_bus.egress_mask};
            case (got.action)
                lsf_pkg::ACT_FORWARD: seen_forward++;
                lsf_pkg::ACT_FLOOD:   seen_flood++;
                lsf_pkg::ACT_FILTER:  seen_filter++;
                default: ;
            endcase
            if (pending_decisions.size() == 0) begin
                report_fault($sformatf("unexpected word: action %0d port %0d mask %02h",
                                       got.action, got.egress_port, got.egress_mask));
            end else begin
                want = pending_decisions.pop_front();
                if (got !== want)
                    report_fault($sformatf(
                        "mismatch: action %0d/%0d port %0d/%0d mask %02h/%02h (exp/got)",
                        want.action, got.action, want.egress_port, got.egress_port,
                        want.egress_mask, got.egress_mask));
            end
        end
    end

    initial begin
        #1_000_000;
        $display("learning_switch_forwarding regression: fail");
        $finish;
    end

    initial begin
        logic [lsf_pkg::CNT_W-1:0] plan [PHASES];
        lsf_pkg::t_addr src;
        lsf_pkg::t_addr dst;
        t_decision      none;
        bit             known;
        int             r;

        plan    = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd8, 4'd2};
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        hdr_bus.valid               <= 1'b0;
        hdr_bus.source_address      <= '0;
        hdr_bus.destination_address <= '0;
        hdr_bus.ingress_port        <= '0;
        fault_count   = 0;
        headers_sent  = 0;
        seen_forward  = 0;
        seen_flood    = 0;
        seen_filter   = 0;
        settings_run  = 1;
        quiet_phase   = 1'b0;
        stall_request = 0;
        none          = '0;
        active_ports  = lsf_pkg::PORTS_IN_USE_RESET;
        for (int i = 0; i < lsf_pkg::TABLE_ENTRIES; i++) begin
            mac_valid[i] = 1'b0;
            mac_key[i]   = '0;
            mac_port[i]  = '0;
        end

        // src, dst, ingress, typed, action, port, mask (all with ports_in_use at reset)
        add_row(48'h0000_0000_0000, lsf_pkg::BROADCAST_ADDR, 3'd0, 1,
                lsf_pkg::ACT_FLOOD, 3'd0, 8'hFE);
        add_row(48'h0000_0000_0001, 48'h0000_0000_0000, 3'd7, 1,
                lsf_pkg::ACT_FORWARD, 3'd0, 8'h01);
        // source learned before lookup, so dst == src filters
        add_row(48'h0000_0000_0000, 48'h0000_0000_0000, 3'd3, 1,
                lsf_pkg::ACT_FILTER, 3'd0, 8'h00);
        add_row(48'h8000_0000_0000, 48'h0000_0000_0001, 3'd7, 1,
                lsf_pkg::ACT_FILTER, 3'd0, 8'h00);
        // all-ones source is learned like any other address
        add_row(lsf_pkg::BROADCAST_ADDR, lsf_pkg::BROADCAST_ADDR, 3'd7, 1,
                lsf_pkg::ACT_FLOOD, 3'd0, 8'h7F);
        add_row(48'hFFFF_FFFF_FFFE, 48'h8000_0000_0000, 3'd0, 1,
                lsf_pkg::ACT_FORWARD, 3'd7, 8'h80);
        add_row(48'h0123_4567_89AB, 48'h5555_5555_5555, 3'd4, 1,
                lsf_pkg::ACT_FLOOD, 3'd0, 8'hEF);
        add_row(48'h5555_5555_5555, 48'h0123_4567_89AB, 3'd4, 1,
                lsf_pkg::ACT_FILTER, 3'd0, 8'h00);
        add_row(48'hAAAA_AAAA_AAAA, 48'hFFFF_FFFF_FFFE, 3'd5, 0, '0, '0, '0);
        add_row(48'hFFFF_FFFF_FFFE, 48'hAAAA_AAAA_AAAA, 3'd2, 0, '0, '0, '0);
        add_row(48'hAAAA_AAAA_AAAA, 48'hFFFF_FFFF_FFFE, 3'd6, 0, '0, '0, '0);
        // fill the remaining slots
        add_row(48'h02AA_0000_0001, 48'h7FFF_FFFF_FFFF, 3'd0, 0, '0, '0, '0);
        add_row(48'h02AA_0000_0002, 48'h7FFF_FFFF_FFFF, 3'd1, 0, '0, '0, '0);
        add_row(48'h02AA_0000_0003, 48'h7FFF_FFFF_FFFF, 3'd2, 0, '0, '0, '0);
        add_row(48'h02AA_0000_0004, 48'h7FFF_FFFF_FFFF, 3'd3, 0, '0, '0, '0);
        add_row(48'h02AA_0000_0005, 48'h7FFF_FFFF_FFFF, 3'd4, 0, '0, '0, '0);
        add_row(48'h02AA_0000_0006, 48'h7FFF_FFFF_FFFF, 3'd5, 0, '0, '0, '0);
        add_row(48'h02AA_0000_0007, 48'h7FFF_FFFF_FFFF, 3'd6, 0, '0, '0, '0);
        add_row(48'h02AA_0000_0008, 48'h7FFF_FFFF_FFFF, 3'd7, 0, '0, '0, '0);
        // table full: new sources are not learned, so dst == src floods
        add_row(48'hFFFF_FFFF_FFFD, lsf_pkg::BROADCAST_ADDR, 3'd1, 1,
                lsf_pkg::ACT_FLOOD, 3'd0, 8'hFD);
        add_row(48'h0000_0000_0002, 48'hFFFF_FFFF_FFFD, 3'd2, 1,
                lsf_pkg::ACT_FLOOD, 3'd0, 8'hFB);
        add_row(48'hFFFF_FFFF_FFFD, 48'hFFFF_FFFF_FFFD, 3'd3, 1,
                lsf_pkg::ACT_FLOOD, 3'd0, 8'hF7);
        // port updates of known entries still work when full
        add_row(48'h0000_0000_0000, 48'hAAAA_AAAA_AAAA, 3'd1, 1,
                lsf_pkg::ACT_FORWARD, 3'd6, 8'h40);
        add_row(48'h0000_0000_0001, 48'h0000_0000_0000, 3'd1, 1,
                lsf_pkg::ACT_FILTER, 3'd0, 8'h00);

        // pool: every address of the script, plus a few fresh ones
        foreach (header_script[i]) begin
            for (int k = 0; k < 2; k++) begin
                src   = k ? header_script[i].dst : header_script[i].src;
                known = (src == lsf_pkg::BROADCAST_ADDR && k == 1);
                foreach (addr_pool[j]) if (addr_pool[j] == src) known = 1'b1;
                if (!known) addr_pool = {addr_pool, src};
            end
        end
        repeat (6) addr_pool = {addr_pool, random_addr()};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (header_script[i])
            send_header(header_script[i].src, header_script[i].dst, header_script[i].ingress,
                        header_script[i].typed, header_script[i].want, pick_gap(1'b0));
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_ports_in_use(plan[ph]);
            settings_run++;
            quiet_phase = ($urandom_range(0, 3) == 0) || (ph == PRESSURE_PHASE);
            // receiver holds off while headers keep coming, so the block backs up
            if (ph == PRESSURE_PHASE) stall_request = PRESSURE_CYCLES;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(0, 9);
                if (r < 8)       src = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
                else if (r == 8) src = random_addr();
                else             src = $urandom_range(0, 1) ? lsf_pkg::BROADCAST_ADDR : '0;
                r = $urandom_range(0, 19);
                if (r < 3)       dst = lsf_pkg::BROADCAST_ADDR;
                else if (r == 3) dst = src;
                else if (r < 6)  dst = random_addr();
                else             dst = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
                send_header(src, dst, lsf_pkg::t_port'($urandom_range(0, 7)), 1'b0, none,
                            pick_gap(quiet_phase));
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d headers under %0d port-count settings (incl. 0 and 15)",
                 headers_sent, settings_run);
        $display("decisions seen: %0d forward, %0d flood, %0d filter; %0d faults",
                 seen_forward, seen_flood, seen_filter, fault_count);
        if (fault_count == 0 && pending_decisions.size() == 0) begin
            $display("learning_switch_forwarding regression: pass");
        end else begin
            $display("learning_switch_forwarding regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
src/lsf_pkg.sv
src/lsf_hdr_if.sv
src/lsf_res_if.sv
src/lsf_cfg_regs.sv
src/lsf_mac_table.sv
src/learning_switch_forwarding.sv
verif/tb_learning_switch_forwarding.sv
